>>> rtl/bdq_pkg.sv
package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int ACTION_W  = 3;
  localparam int STATUS_W  = 2;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DELETE     = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHL,
    CELL_SHR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     sel;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_DELETE
  } state_t;

endpackage

>>> rtl/bounded_deque_with_value_delete.sv
// push, pop, clear and unused codes give a registered result in the cycle after the request is taken
// delete visits each of the n stored entries once: the cell chain rotates one entry per cycle
// throughput: one request per cycle while results are taken; none taken during a delete
// reset clears the entry count and the result valid; stored values are not cleared
// since only occupied cells are ever read
module bounded_deque_with_value_delete
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] action,
  input  logic signed [DATA_W-1:0] item_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [CW-1:0]       entry_count,
  output logic [CW-1:0]       removed_count
);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] steps, steps_next;
  logic [CW-1:0] n_orig, n_orig_next;
  logic [DATA_W-1:0] del_val, del_val_next;

  logic [DATA_W-1:0] cell_data [DEPTH];
  cell_ctl_t         cell_ctl  [DEPTH];

  cell_op_t          op;
  logic              load_en;
  logic [CW-1:0]     load_idx;
  logic [DATA_W-1:0] load_data;

  logic                accept;
  logic                out_load;
  logic [STATUS_W-1:0] res_status;
  logic [CW-1:0]       res_count;
  logic [CW-1:0]       res_removed;
  logic                keep;
  logic                full;
  logic                empty;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign accept = in_valid && in_ready;
  assign keep   = (cell_data[0] != del_val);

  always_comb begin
    state_next  = state;
    count_next  = count;
    steps_next  = steps;
    n_orig_next = n_orig;
    del_val_next = del_val;
    op          = CELL_HOLD;
    load_en     = 1'b0;
    load_idx    = count;
    load_data   = item_value;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    res_status  = STAT_DONE;
    res_count   = count;
    res_removed = '0;
    case (state)
      S_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (accept) begin
          out_load = 1'b1;
          case (action)
            ACT_PUSH_FRONT: begin
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                op         = CELL_SHR;
                count_next = count + CW'(1);
              end
            end
            ACT_PUSH_BACK: begin
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                load_en    = 1'b1;
                count_next = count + CW'(1);
              end
            end
            ACT_POP_FRONT: begin
              if (empty) begin
                res_status = STAT_EMPTY;
              end else begin
                op          = CELL_SHL;
                count_next  = count - CW'(1);
                res_removed = CW'(1);
              end
            end
            ACT_POP_BACK: begin
              if (empty) begin
                res_status = STAT_EMPTY;
              end else begin
                count_next  = count - CW'(1);
                res_removed = CW'(1);
              end
            end
            ACT_DELETE: begin
              if (!empty) begin
                out_load     = 1'b0;
                state_next   = S_DELETE;
                steps_next   = count;
                n_orig_next  = count;
                del_val_next = item_value;
              end
            end
            ACT_CLEAR: begin
              count_next  = '0;
              res_removed = count;
            end
            default: ;
          endcase
          res_count = count_next;
        end
      end
      S_DELETE: begin
        // pop the front entry; a kept one goes back in at the tail
        op        = CELL_SHL;
        load_en   = keep;
        load_idx  = count - CW'(1);
        load_data = cell_data[0];
        if (!keep) begin
          count_next = count - CW'(1);
        end
        steps_next = steps - CW'(1);
        if (steps == CW'(1)) begin
          state_next  = S_IDLE;
          out_load    = 1'b1;
          res_count   = count_next;
          res_removed = n_orig - count_next;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    steps   <= steps_next;
    n_orig  <= n_orig_next;
    del_val <= del_val_next;
    if (out_load) begin
      status        <= res_status;
      entry_count   <= res_count;
      removed_count <= res_removed;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = item_value;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    assign cell_ctl[i].op  = op;
    assign cell_ctl[i].sel = load_en && (load_idx == CW'(i));

    bdq_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .left      (left_data),
      .right     (right_data),
      .load_data (load_data),
      .data      (cell_data[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_delete_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_DELETE) |-> !in_ready)
    else $error("request taken during delete");

  a_delete_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_DELETE) |-> (steps != '0) && (count >= steps))
    else $error("delete step count out of range");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count == count))
    else $error("result count differs from stored count");

  a_result_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, entry_count} + {1'b0, removed_count} <= (CW + 1)'(DEPTH)))
    else $error("removed plus remaining above depth");

endmodule

>>> rtl/bdq_cell.sv
module bdq_cell
  import bdq_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  input  logic [DATA_W-1:0] load_data,
  output logic [DATA_W-1:0] data
);

  logic [DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctl.sel) begin
      data_next = load_data;
    end else begin
      case (ctl.op)
        CELL_SHL: data_next = right;
        CELL_SHR: data_next = left;
        default:  data_next = data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
